/* design/let_pkg.sv */
// Shared types, constants and register codes of the leading-edge trigger.
`timescale 1ns / 1ps
`default_nettype none
package let_pkg;

    // Default sizes of the history and the trace
    localparam int DEF_MAX_FILTER_K = 64;
    localparam int DEF_MAX_TRACE    = 1024;

    // Field widths
    localparam int SAMPLE_W   = 14;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SUM_W      = DIFF_W + 2;
    localparam int THR_W      = 15;
    localparam int K_W        = 7;
    localparam int START_W    = 10;
    localparam int EDGE_W     = 11;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_K    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 2'd2;

    // Register reset values
    localparam int RST_THRESHOLD   = 100;
    localparam int RST_FILTER_K    = 8;
    localparam int RST_START_INDEX = 0;

    // Filter geometry: five differences around the evaluated position
    localparam int TAPS       = 5;
    localparam int EVAL_LAG   = 2;   // position trails the newest sample
    localparam int SEARCH_OFS = 2;   // search opens this far past start_index

    // Queue depths
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [THR_W-1:0]    t_thr;
    typedef logic [K_W-1:0]             t_k;
    typedef logic [START_W-1:0]         t_start;
    typedef logic [EDGE_W-1:0]          t_idx;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    typedef struct packed {
        t_thr   threshold;
        t_k     filter_k;
        t_start start_index;
    } t_cfg;

    // Per-sample control carried from the front to the decision stage
    typedef struct packed {
        logic eval;   // position is inside the search window
        logic last;   // final sample of the trace
        t_idx pos;    // evaluated position
        t_idx len;    // trace length after this sample
    } t_item_meta;

    typedef struct packed {
        t_diff [TAPS-1:0] d;
        t_item_meta       meta;
    } t_mid_item;

    typedef struct packed {
        t_idx edge_index;
        logic found;
    } t_result;

endpackage
`default_nettype wire

/* design/let_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module let_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/let_fifo.sv */
// Small first-word-fall-through queue with an occupancy count.
`timescale 1ns / 1ps
`default_nettype none
module let_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic      [WIDTH-1:0]               o_data,
    output logic                                o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign w_do_push = i_push && (r_count != CW'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/let_front.sv */
// Front end: sample intake, history RAM, difference taps and search-window tagging.
`timescale 1ns / 1ps
`default_nettype none
module let_front #(
    parameter int MAX_FILTER_K = let_pkg::DEF_MAX_FILTER_K,
    parameter int MAX_TRACE    = let_pkg::DEF_MAX_TRACE
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire let_pkg::t_sample               i_sample,
    input  wire logic                           i_last_of_trace,
    input  wire let_pkg::t_cfg                  i_cfg,
    input  wire logic                           i_k_written,
    input  wire logic [let_pkg::MID_CNT_W-1:0]  i_mid_count,
    output logic                                o_mid_push,
    output let_pkg::t_mid_item                  o_mid_item
);
    import let_pkg::*;

    localparam int DEPTH      = MAX_FILTER_K + TAPS;
    localparam int AW         = $clog2(DEPTH);
    localparam int KW         = $clog2(MAX_FILTER_K + 1);
    localparam int KCW        = (K_W > KW) ? K_W : KW;
    localparam int CW         = $clog2(MAX_TRACE + 1);
    localparam int NW         = ((CW > KW) ? CW : KW) + 1;
    localparam int SW         = ((CW > START_W) ? CW : START_W) + 1;
    localparam int OFS_W      = $clog2(TAPS);
    localparam int RF_SLOTS   = TAPS - 1;
    localparam int RF_W       = (RF_SLOTS > 1) ? $clog2(RF_SLOTS) : 1;
    localparam int EVAL_START = EVAL_LAG + SEARCH_OFS;
    localparam int FW         = MID_CNT_W + 1;

    // RAM address of sample (count - ofs - k), wrapped around the history
    function automatic logic [AW-1:0] hist_addr(input logic [AW-1:0] wp,
                                                input logic [KW-1:0] k,
                                                input logic [OFS_W-1:0] ofs);
        logic [AW:0] back;
        logic [AW:0] here;
        back = (AW+1)'(k) + (AW+1)'(ofs);
        here = {1'b0, wp};
        if (here >= back) begin
            return AW'(here - back);
        end
        return AW'(here + (AW+1)'(DEPTH) - back);
    endfunction

    // Sample (count - ofs - k) lies before the trace start
    function automatic logic before_start(input logic [CW-1:0] cnt,
                                          input logic [KW-1:0] k,
                                          input logic [OFS_W-1:0] ofs);
        return NW'(cnt) < (NW'(k) + NW'(ofs));
    endfunction

    logic [KW-1:0] w_k;
    logic          w_accept;
    logic          w_active;
    logic [AW-1:0] w_raddr;
    t_sample       w_rdata;
    logic [FW-1:0] w_inflight;

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_wp;

    // intake stage
    logic          r_f1_valid;
    t_sample       r_f1_sample;
    logic          r_f1_act;
    logic          r_f1_kz;
    logic          r_f1_neg;
    t_item_meta    r_f1_meta;

    // tap stage
    t_sample       r_cur [TAPS];
    t_sample       r_dly [TAPS];
    t_sample       w_base_cur [TAPS-1];
    t_sample       w_base_dly [TAPS-1];
    t_sample       w_new_dly;
    logic          r_fresh;
    logic          r_f2_valid;
    t_item_meta    r_f2_meta;

    // delayed-tap reload after a filter_k change
    logic            r_rf_busy;
    logic [RF_W-1:0] r_rf_n;
    logic            r_rf_ld;
    logic [RF_W-1:0] r_rf_ld_n;
    logic            r_rf_ld_neg;

    assign w_k = (KCW'(i_cfg.filter_k) > KCW'(MAX_FILTER_K)) ? KW'(MAX_FILTER_K)
                                                            : KW'(i_cfg.filter_k);

    assign w_inflight = FW'(i_mid_count) + FW'(r_f1_valid) + FW'(r_f2_valid);
    assign o_full     = r_rf_busy || r_rf_ld || (w_inflight >= FW'(MID_DEPTH));
    assign w_accept   = i_push && !o_full;
    assign w_active   = (r_count < CW'(MAX_TRACE));

    assign w_raddr = r_rf_busy ? hist_addr(r_wp, w_k, OFS_W'(r_rf_n) + 1'b1)
                               : hist_addr(r_wp, w_k, '0);

    let_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_active),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sample counter and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= '0;
        end else if (w_accept) begin
            if (i_last_of_trace) begin
                r_count <= '0;
                r_wp    <= '0;
            end else if (w_active) begin
                r_count <= r_count + 1'b1;
                r_wp    <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
        end
    end

    // intake stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_sample    <= i_sample;
            r_f1_act       <= w_active;
            r_f1_kz        <= (w_k == '0);
            r_f1_neg       <= before_start(r_count, w_k, '0);
            r_f1_meta.eval <= w_active &&
                              (SW'(r_count) >= SW'(i_cfg.start_index) + SW'(EVAL_START));
            r_f1_meta.last <= i_last_of_trace;
            r_f1_meta.pos  <= t_idx'(r_count - CW'(EVAL_LAG));
            r_f1_meta.len  <= w_active ? t_idx'(r_count + 1'b1) : t_idx'(r_count);
        end
    end

    // taps read as zero right after a trace ends
    always_comb begin
        for (int n = 0; n < TAPS - 1; n++) begin
            w_base_cur[n] = r_fresh ? '0 : r_cur[n];
            w_base_dly[n] = r_fresh ? '0 : r_dly[n];
        end
        if (r_f1_kz) begin
            w_new_dly = r_f1_sample;
        end else if (r_f1_neg) begin
            w_new_dly = '0;
        end else begin
            w_new_dly = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid && r_f1_act) begin
            r_cur[0] <= r_f1_sample;
            r_dly[0] <= w_new_dly;
            for (int n = 1; n < TAPS; n++) begin
                r_cur[n] <= w_base_cur[n-1];
                r_dly[n] <= w_base_dly[n-1];
            end
        end else if (r_rf_ld) begin
            r_dly[OFS_W'(r_rf_ld_n)] <= r_rf_ld_neg ? '0 : w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_f2_valid <= 1'b0;
        end else begin
            r_f2_valid <= r_f1_valid;
            if (r_f1_valid) begin
                r_fresh <= r_f1_meta.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_f2_meta <= r_f1_meta;
        end
    end

    // reload the delayed taps with the new distance, one RAM read a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_busy <= 1'b0;
            r_rf_n    <= '0;
            r_rf_ld   <= 1'b0;
        end else begin
            r_rf_ld <= r_rf_busy;
            if (i_k_written) begin
                r_rf_busy <= 1'b1;
                r_rf_n    <= '0;
            end else if (r_rf_busy) begin
                r_rf_n <= r_rf_n + 1'b1;
                if (r_rf_n == RF_W'(RF_SLOTS - 1)) begin
                    r_rf_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rf_busy) begin
            r_rf_ld_n   <= r_rf_n;
            r_rf_ld_neg <= before_start(r_count, w_k, OFS_W'(r_rf_n) + 1'b1);
        end
    end

    // differences toward the queue
    assign o_mid_push = r_f2_valid;
    always_comb begin
        o_mid_item.meta = r_f2_meta;
        for (int n = 0; n < TAPS; n++) begin
            o_mid_item.d[n] = t_diff'(r_cur[n]) - t_diff'(r_dly[n]);
        end
    end

endmodule
`default_nettype wire

/* design/let_back.sv */
// Back end: double 1-2-1 smoothing, threshold compare and edge decision.
`timescale 1ns / 1ps
`default_nettype none
module let_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_mid_empty,
    input  wire let_pkg::t_mid_item             i_mid_item,
    output logic                                o_mid_pop,
    input  wire let_pkg::t_thr                  i_threshold,
    input  wire logic [let_pkg::OUT_CNT_W-1:0]  i_out_count,
    output logic                                o_out_push,
    output let_pkg::t_result                    o_out_item
);
    import let_pkg::*;

    localparam int ROUND_BIAS = 3;
    localparam int DIV_SHIFT  = 2;
    localparam int OW         = OUT_CNT_W + 1;

    // divide by four, truncating toward zero
    function automatic t_diff div4(input t_sum x);
        t_sum adj;
        adj = x[SUM_W-1] ? x + t_sum'(ROUND_BIAS) : x;
        return t_diff'(adj >>> DIV_SHIFT);
    endfunction

    function automatic t_sum sum121(input t_diff a, input t_diff b, input t_diff c);
        return t_sum'(a) + (t_sum'(b) <<< 1) + t_sum'(c);
    endfunction

    t_diff      w_d [TAPS];
    logic       w_level;

    logic       r_b1_valid;
    t_diff      r_s1;
    t_diff      r_s2;
    t_diff      r_s3;
    t_item_meta r_b1_meta;

    logic       r_b2_valid;
    t_diff      r_dd;
    t_item_meta r_b2_meta;

    logic       r_prev;
    logic       r_done;
    logic       n_prev;
    logic       n_done;

    // room check covers every item already in the smoothing stages
    assign o_mid_pop = !i_mid_empty &&
                       ((OW'(i_out_count) + OW'(r_b1_valid) + OW'(r_b2_valid)) < OW'(OUT_DEPTH));

    always_comb begin
        for (int n = 0; n < TAPS; n++) begin
            w_d[n] = i_mid_item.d[n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            r_b1_valid <= o_mid_pop;
            r_b2_valid <= r_b1_valid;
        end
    end

    // d[0] is the newest difference; ordering is symmetric so either end works
    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_s1      <= div4(sum121(w_d[4], w_d[3], w_d[2]));
            r_s2      <= div4(sum121(w_d[3], w_d[2], w_d[1]));
            r_s3      <= div4(sum121(w_d[2], w_d[1], w_d[0]));
            r_b1_meta <= i_mid_item.meta;
        end
        if (r_b1_valid) begin
            r_dd      <= div4(sum121(r_s1, r_s2, r_s3));
            r_b2_meta <= r_b1_meta;
        end
    end

    assign w_level = (i_threshold > 0) ? (r_dd > i_threshold) : (r_dd < i_threshold);

    always_comb begin
        n_prev                = r_prev;
        n_done                = r_done;
        o_out_push            = 1'b0;
        o_out_item.edge_index = r_b2_meta.pos;
        o_out_item.found      = 1'b1;
        if (r_b2_valid) begin
            if (r_b2_meta.eval && !r_done) begin
                if (w_level && !r_prev) begin
                    o_out_push = 1'b1;
                    n_done     = 1'b1;
                end
                n_prev = w_level;
            end
            if (r_b2_meta.last) begin
                if (!n_done) begin
                    o_out_push            = 1'b1;
                    o_out_item.edge_index = r_b2_meta.len;
                    o_out_item.found      = 1'b0;
                end
                n_prev = 1'b0;
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_prev <= n_prev;
            r_done <= n_done;
        end
    end

endmodule
`default_nettype wire

/* design/leading_edge_trigger.sv */
// Top level of the leading-edge trigger: config registers, front, queues, back.
`timescale 1ns / 1ps
`default_nettype none
// Leading-edge trigger. One signed ADC sample per transfer, in trace order, with
// last_of_trace on the final sample. For each position i the block forms the
// K-sample differences around i, smooths them twice with a 1-2-1 kernel (each
// pass divides by four, truncating toward zero) and compares against threshold:
// a positive threshold triggers on "above", zero or negative on "below". It
// reports the first position at or after start_index+2 where that level goes
// from 0 to 1 (found=1), or, if none, the trace length at the last sample
// (found=0); at most one result per trace. Position i is judged when sample i+2
// arrives, so the last two positions of a trace are never judged. Samples past
// MAX_TRACE-1 are dropped and the length saturates at MAX_TRACE; filter_k above
// MAX_FILTER_K is clamped, filter_k of zero never triggers; start_index should
// be at least filter_k (earlier samples read as zero). Throughput is one sample
// per clock while full is low; with neither queue backed up, a result reaches
// the output ports through two front stages, the middle queue, two smoothing
// stages and the result queue. The history lives in a (MAX_FILTER_K+5)-entry
// RAM with one read port; after a write to filter_k the block holds full high
// while it rereads four history entries through that port. Write configuration
// only while the block is idle.
module leading_edge_trigger #(
    parameter int MAX_FILTER_K = let_pkg::DEF_MAX_FILTER_K,
    parameter int MAX_TRACE    = let_pkg::DEF_MAX_TRACE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // sample input queue
    input  wire logic                  push,
    output logic                       full,
    input  wire let_pkg::t_sample      i_sample,
    input  wire logic                  i_last_of_trace,
    // result output queue
    output logic                       empty,
    input  wire logic                  pop,
    output let_pkg::t_idx              o_edge_index,
    output logic                       o_found,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire let_pkg::t_cfg_idx     i_cfg_idx,
    input  wire let_pkg::t_cfg_data    i_cfg_wdata
);
    import let_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_k_written;

    t_mid_item            w_front_item;
    logic                 w_front_push;
    t_mid_item            w_back_item;
    logic                 w_mid_empty;
    logic                 w_mid_pop;
    logic [MID_CNT_W-1:0] w_mid_count;

    t_result              w_result;
    logic                 w_result_push;
    t_result              w_out_item;
    logic [OUT_CNT_W-1:0] w_out_count;

    // Configuration registers; a filter_k write also triggers the tap reload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= t_thr'(RST_THRESHOLD);
            r_cfg.filter_k    <= t_k'(RST_FILTER_K);
            r_cfg.start_index <= t_start'(RST_START_INDEX);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:   r_cfg.threshold   <= t_thr'(i_cfg_wdata);
                CFG_FILTER_K:    r_cfg.filter_k    <= i_cfg_wdata[K_W-1:0];
                CFG_START_INDEX: r_cfg.start_index <= i_cfg_wdata[START_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign w_k_written = i_cfg_we && (i_cfg_idx == CFG_FILTER_K);

    // Front: intake, history and differences
    let_front #(
        .MAX_FILTER_K (MAX_FILTER_K),
        .MAX_TRACE    (MAX_TRACE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_sample        (i_sample),
        .i_last_of_trace (i_last_of_trace),
        .i_cfg           (r_cfg),
        .i_k_written     (w_k_written),
        .i_mid_count     (w_mid_count),
        .o_mid_push      (w_front_push),
        .o_mid_item      (w_front_item)
    );

    // Queue between front and back so each side stalls on its own
    let_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_item),
        .i_pop   (w_mid_pop),
        .o_data  (w_back_item),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    // Back: smoothing, compare and edge decision
    let_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_mid_item  (w_back_item),
        .o_mid_pop   (w_mid_pop),
        .i_threshold (r_cfg.threshold),
        .i_out_count (w_out_count),
        .o_out_push  (w_result_push),
        .o_out_item  (w_result)
    );

    // Result queue; holds results while the consumer stalls
    let_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_result_push),
        .i_data  (w_result),
        .i_pop   (pop),
        .o_data  (w_out_item),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_edge_index = w_out_item.edge_index;
    assign o_found      = w_out_item.found;

endmodule
`default_nettype wire
